[sv/mavg_pkg.sv]
`timescale 1ns / 1ps
// Shared constants and controller/datapath handshake types for the moving average block.
package mavg_pkg;

  // Window length register
  localparam int          LEN_BITS  = 11;
  localparam logic [10:0] LEN_RESET = 11'd20;

  // Item op codes
  localparam logic OP_PUSH    = 1'b0;
  localparam logic OP_REPLACE = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;   // latch the input beat and precompute addresses
    logic mem_read;  // read the sample that leaves the sum
    logic update;    // write the new sample, update sum, fill and newest slot
    logic div_load;  // load the divider from the new sum and fill
    logic div_step;  // one restoring division step
    logic out_load;  // move the quotient into the output register
  } mavg_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic div_last;  // current division step is the final one
    logic out_free;  // output register can take a new result this cycle
  } mavg_status_t;

endpackage

[sv/mavg_in_if.sv]
`timescale 1ns / 1ps
// Input channel: op and sample with valid/ready handshake.
interface mavg_in_if #(
  parameter int SAMPLE_BITS = 32
) ();
  logic                          valid;
  logic                          ready;
  logic                          op;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output op, output sample, input ready);
  modport sink   (input valid, input op, input sample, output ready);
endinterface

[sv/mavg_out_if.sv]
`timescale 1ns / 1ps
// Output channel: average with valid/ready handshake.
interface mavg_out_if #(
  parameter int SAMPLE_BITS = 32
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] average;

  modport source (output valid, output average, input ready);
  modport sink   (input valid, input average, output ready);
endinterface

[sv/mavg_ctrl.sv]
`timescale 1ns / 1ps
// Sequencer for the moving average: read, update, divide, deliver.
module mavg_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  mavg_pkg::mavg_status_t status,
  output mavg_pkg::mavg_cmd_t    cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_READ   = 3'd1;
  localparam logic [2:0] S_UPDATE = 3'd2;
  localparam logic [2:0] S_SETUP  = 3'd3;
  localparam logic [2:0] S_DIVIDE = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_READ;
        end
      end
      S_READ: begin
        cmd.mem_read = 1'b1;
        state_next   = S_UPDATE;
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_next = S_SETUP;
      end
      S_SETUP: begin
        cmd.div_load = 1'b1;
        state_next   = S_DIVIDE;
      end
      S_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_accept_reads: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_READ))
    else $error("accepted beat did not start a memory read");

  a_load_needs_room: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> status.out_free)
    else $error("result loaded over an untaken beat");

  a_single_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cmd))
    else $error("more than one datapath command at once");

endmodule

[sv/mavg_datapath.sv]
`timescale 1ns / 1ps
// Sample ring, running sum, fill tracking and restoring divider.
module mavg_datapath #(
  parameter int MAX_WINDOW  = 1024,
  parameter int SAMPLE_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [mavg_pkg::LEN_BITS-1:0]       cfg_wdata,
  input  logic                                in_op,
  input  logic signed [SAMPLE_BITS-1:0]       in_sample,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [SAMPLE_BITS-1:0]       out_average,
  input  mavg_pkg::mavg_cmd_t                 cmd,
  output mavg_pkg::mavg_status_t              status
);

  localparam int PTR_W = $clog2(MAX_WINDOW);
  localparam int CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int AW    = CNT_W + 1;
  localparam int SUM_W = SAMPLE_BITS + $clog2(MAX_WINDOW);
  localparam int STP_W = $clog2(SUM_W + 1);

  logic [SAMPLE_BITS-1:0] hist_mem [MAX_WINDOW];
  logic [SAMPLE_BITS-1:0] rdata;

  logic [mavg_pkg::LEN_BITS-1:0] window_length;
  logic [PTR_W-1:0]              newest;
  logic [CNT_W-1:0]              fill;
  logic [SUM_W-1:0]              sum;

  // latched item
  logic [SAMPLE_BITS-1:0] item_sample;
  logic                   item_sub;
  logic [PTR_W-1:0]       rd_addr;
  logic [PTR_W-1:0]       wr_addr;
  logic [CNT_W-1:0]       fill_upd;

  // divider
  logic                   neg;
  logic [CNT_W-1:0]       divisor;
  logic [CNT_W-1:0]       rem;
  logic [SUM_W-1:0]       quo;
  logic [STP_W-1:0]       steps;

  // combinational helpers
  logic [31:0]            len32;
  logic [CNT_W-1:0]       len;
  logic [PTR_W-1:0]       slot_next;
  logic [AW-1:0]          old_diff;
  logic [AW-1:0]          old_wrap;
  logic [PTR_W-1:0]       oldest;
  logic                   is_replace;
  logic                   is_drop;
  logic [SUM_W-1:0]       sub_ext;
  logic [SUM_W-1:0]       add_ext;
  logic [CNT_W+1:0]       trial;
  logic [SAMPLE_BITS-1:0] q_low;

  // Effective length: zero acts as one, oversize clamps to the ring depth
  always_comb begin
    if (window_length == '0) begin
      len32 = 32'd1;
    end else if (32'(window_length) > 32'(MAX_WINDOW)) begin
      len32 = 32'(MAX_WINDOW);
    end else begin
      len32 = 32'(window_length);
    end
    len = len32[CNT_W-1:0];
  end

  assign slot_next  = (newest == PTR_W'(MAX_WINDOW - 1)) ? '0 : newest + 1'b1;
  assign old_diff   = AW'(slot_next) + AW'(MAX_WINDOW) - AW'(len);
  assign old_wrap   = (old_diff >= AW'(MAX_WINDOW)) ? old_diff - AW'(MAX_WINDOW) : old_diff;
  assign oldest     = old_wrap[PTR_W-1:0];
  assign is_replace = (in_op == mavg_pkg::OP_REPLACE) && (fill != '0);
  assign is_drop    = !is_replace && (fill >= len);

  assign sub_ext = item_sub ? {{(SUM_W-SAMPLE_BITS){rdata[SAMPLE_BITS-1]}}, rdata} : '0;
  assign add_ext = {{(SUM_W-SAMPLE_BITS){item_sample[SAMPLE_BITS-1]}}, item_sample};

  assign trial = {1'b0, rem, quo[SUM_W-1]} - {2'b00, divisor};
  assign q_low = quo[SAMPLE_BITS-1:0];

  assign status.div_last = (steps == STP_W'(1));
  assign status.out_free = !out_valid || out_ready;

  // Sample ring
  always_ff @(posedge clk) begin
    if (cmd.mem_read) begin
      rdata <= hist_mem[rd_addr];
    end
    if (cmd.update) begin
      hist_mem[wr_addr] <= item_sample;
    end
  end

  // Window state
  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= mavg_pkg::LEN_RESET;
      newest        <= '0;
      fill          <= '0;
      sum           <= '0;
    end else if (cfg_we) begin
      window_length <= cfg_wdata;
      newest        <= '0;
      fill          <= '0;
      sum           <= '0;
    end else if (cmd.update) begin
      newest <= wr_addr;
      fill   <= fill_upd;
      sum    <= sum - sub_ext + add_ext;
    end
  end

  // Item latch
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_sample <= in_sample;
      item_sub    <= is_replace || is_drop;
      rd_addr     <= is_replace ? newest : oldest;
      wr_addr     <= is_replace ? newest : slot_next;
      if (is_replace) begin
        fill_upd <= fill;
      end else if (is_drop) begin
        fill_upd <= len;
      end else begin
        fill_upd <= fill + 1'b1;
      end
    end
  end

  // Restoring divider, one quotient bit per step
  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
    end else if (cmd.div_load) begin
      steps <= STP_W'(SUM_W);
    end else if (cmd.div_step) begin
      steps <= steps - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      neg     <= sum[SUM_W-1];
      quo     <= sum[SUM_W-1] ? -sum : sum;
      rem     <= '0;
      divisor <= fill;
    end else if (cmd.div_step) begin
      if (!trial[CNT_W+1]) begin
        rem <= trial[CNT_W-1:0];
        quo <= {quo[SUM_W-2:0], 1'b1};
      end else begin
        rem <= {rem[CNT_W-2:0], quo[SUM_W-1]};
        quo <= {quo[SUM_W-2:0], 1'b0};
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_average <= neg ? -q_low : q_low;
    end
  end

  a_fill_bounded: assert property (@(posedge clk) disable iff (rst)
    fill <= len)
    else $error("fill count exceeds window length");

  a_divisor_nonzero: assert property (@(posedge clk) disable iff (rst)
    cmd.div_load |-> (fill != '0))
    else $error("division by an empty window");

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    $past(cmd.div_step) |-> (rem < divisor))
    else $error("divider remainder not reduced");

endmodule

[sv/moving_average_with_replace_core.sv]
`timescale 1ns / 1ps
// Moving average with push/replace-latest ops; top level.
// Per item: once the input beat is accepted, the sequencer runs a memory read,
//   the sum update, divider setup, the bit-serial divide and the output load.
// Items: one at a time; a new beat is taken only after the previous result is
//   loaded; the restoring divider works bit-serially (one quotient bit per cycle).
// Reset: synchronous, active high; window empty, window_length = 20, no result pending.
// A config write empties the window at once; ring contents are not cleared.
module moving_average_with_replace_core #(
  parameter int MAX_WINDOW  = 1024,
  parameter int SAMPLE_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  mavg_in_if.sink                       in_ch,
  mavg_out_if.source                    out_ch,
  input  logic                          cfg_we,
  input  logic [mavg_pkg::LEN_BITS-1:0] cfg_wdata
);

  // Command and status buses between sequencer and datapath
  mavg_pkg::mavg_cmd_t    cmd;
  mavg_pkg::mavg_status_t status;

  // The sequencer takes one beat at a time: ready is high only while it waits
  // for work. A finished result sits in the datapath's output register, so a
  // new beat can be taken while the previous average is still unclaimed.
  mavg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath: sample ring memory (single read or write per cycle), running
  // sum of SUM_W bits, fill count, window length register, the divider and
  // the output register. Replace on an empty window falls back to push.
  mavg_datapath #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_op       (in_ch.op),
    .in_sample   (in_ch.sample),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_average (out_ch.average),
    .cmd         (cmd),
    .status      (status)
  );

endmodule

[test/tb_moving_average_with_replace_core.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the push/replace moving average core.
module tb_moving_average_with_replace_core;

  localparam int SAMPLE_W    = 32;
  localparam int MAX_WIN     = 1024;
  localparam int LEN_W       = mavg_pkg::LEN_BITS;
  localparam int CYCLE_LIMIT = 1_000_000;
  // Margin run after the bench drains, before the final verdict.
  localparam int DRAIN_CYCLES = 80;

  // One input beat as it sits in the send queue.
  typedef struct packed {
    logic                       op;
    logic signed [SAMPLE_W-1:0] sample;
  } sample_beat_t;

  logic clk = 1'b0;
  logic rst;
  logic             cfg_we;
  logic [LEN_W-1:0] cfg_wdata;

  mavg_in_if  #(.SAMPLE_BITS(SAMPLE_W)) in_ch ();
  mavg_out_if #(.SAMPLE_BITS(SAMPLE_W)) out_ch ();

  moving_average_with_replace_core #(
    .MAX_WINDOW (MAX_WIN),
    .SAMPLE_BITS(SAMPLE_W)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Window predictor: its own ring, fill count, running sum and length register.
  // The sum is kept 64 bits wide; 1024 full-scale samples need only 42 bits.
  // ---------------------------------------------------------------------------
  logic signed [SAMPLE_W-1:0] win_ring [MAX_WIN];
  logic [9:0]                 win_newest;
  logic [LEN_W-1:0]           win_fill;
  longint                     win_sum;
  logic [LEN_W-1:0]           win_len;

  sample_beat_t               beats_to_send [$];
  logic [SAMPLE_W-1:0]        expected_averages [$];
  int                         mismatch_count = 0;
  int                         cycle_count = 0;

  // Length register as the block uses it: 0 acts as 1, anything past the ring size
  // is clamped to the ring size.
  function automatic int active_window();
    if (win_len == '0) return 1;
    if (int'(win_len) > MAX_WIN) return MAX_WIN;
    return int'(win_len);
  endfunction

  function automatic void clear_window();
    win_newest = '0;
    win_fill   = '0;
    win_sum    = 0;
  endfunction

  // Apply one beat to the window and return the truncated mean.
  function automatic logic [SAMPLE_W-1:0] predict_average(
    input logic op, input logic signed [SAMPLE_W-1:0] sample
  );
    int     len;
    int     slot;
    int     oldest;
    longint quot;
    len = active_window();
    if (op == mavg_pkg::OP_REPLACE && win_fill != '0) begin
      // Replace only swaps the newest entry; fill and position stay put.
      win_sum = win_sum - longint'(win_ring[win_newest]) + longint'(sample);
      win_ring[win_newest] = sample;
    end else begin
      // Push, and also a replace that finds the window empty.
      slot = (int'(win_newest) + 1) % MAX_WIN;
      if (int'(win_fill) >= len) begin
        oldest = (slot + MAX_WIN - len) % MAX_WIN;
        win_sum = win_sum - longint'(win_ring[oldest]);
        win_fill = LEN_W'(len);
      end else begin
        win_fill = win_fill + 1'b1;
      end
      win_ring[slot] = sample;
      win_newest = slot[9:0];
      win_sum = win_sum + longint'(sample);
    end
    // SystemVerilog signed division truncates toward zero, as the block does.
    quot = win_sum / longint'(win_fill);
    return quot[SAMPLE_W-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // Mix of full-range, full-scale and small values; the small ones give negative
  // sums that do not divide evenly, which is where truncation direction shows.
  function automatic logic signed [SAMPLE_W-1:0] draw_sample();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4:          return 32'sh7FFF_FFFF;
      5:          return 32'sh8000_0000;
      6, 7:       return int'($urandom_range(0, 16)) - 8;
      default:    return int'($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
    endcase
  endfunction

  // The first beat of each phase is a replace, so every window setting sees a
  // replace hit an empty window.
  task automatic queue_random_beats(input int count);
    sample_beat_t beat;
    for (int i = 0; i < count; i++) begin
      beat.op     = (i == 0 || $urandom_range(0, 3) == 0) ? mavg_pkg::OP_REPLACE
                                                          : mavg_pkg::OP_PUSH;
      beat.sample = draw_sample();
      beats_to_send.push_back(beat);
    end
  endtask

  task automatic queue_beat(input logic op, input logic signed [SAMPLE_W-1:0] sample);
    sample_beat_t beat;
    beat.op     = op;
    beat.sample = sample;
    beats_to_send.push_back(beat);
  endtask

  // Idle means: nothing left to send, nothing on the input and every result back.
  task automatic wait_drained();
    while (beats_to_send.size() != 0 || in_ch.valid || expected_averages.size() != 0)
      @(posedge clk);
  endtask

  // Write the length register once the block is idle, then load the next phase.
  task automatic run_phase(input logic [LEN_W-1:0] len_value, input int count);
    wait_drained();
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= len_value;
    @(posedge clk);
    cfg_we <= 1'b0;
    // The write took effect at this edge; the window starts empty.
    win_len = len_value;
    clear_window();
    queue_random_beats(count);
  endtask

  // ---------------------------------------------------------------------------
  // Input driver: one beat per queue entry, with a random gap after each accepted
  // beat and occasional stretches with no gaps at all.
  // The predictor runs on each accepted beat, in acceptance order.
  // ---------------------------------------------------------------------------
  int           send_wait;
  logic         send_eager = 1'b0;
  sample_beat_t send_beat;

  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      send_wait   <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        expected_averages.push_back(predict_average(in_ch.op, in_ch.sample));
      if (!in_ch.valid || in_ch.ready) begin
        if (send_wait > 0) begin
          in_ch.valid <= 1'b0;
          send_wait   <= send_wait - 1;
        end else if (beats_to_send.size() != 0) begin
          send_beat = beats_to_send.pop_front();
          in_ch.valid  <= 1'b1;
          in_ch.op     <= send_beat.op;
          in_ch.sample <= send_beat.sample;
          if ($urandom_range(0, 31) == 0) send_eager = ~send_eager;
          send_wait <= send_eager ? 0 : $urandom_range(0, 8);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output monitor: after each result beat, hold ready low for a randomly drawn wait.
  // Every beat is checked against the oldest expected average.
  // ---------------------------------------------------------------------------
  int                  take_wait;
  int                  take_draw;
  logic                take_eager = 1'b0;
  logic [SAMPLE_W-1:0] want_average;

  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      take_wait    <= 0;
    end else if (out_ch.valid && out_ch.ready) begin
      if (expected_averages.size() == 0) begin
        $display("%0t: average beat %h arrived with nothing expected", $time,
                 out_ch.average);
        mismatch_count++;
      end else begin
        want_average = expected_averages.pop_front();
        if (out_ch.average !== want_average) begin
          $display("%0t: average mismatch: expected %h, actual %h", $time,
                   want_average, out_ch.average);
          mismatch_count++;
        end
      end
      if ($urandom_range(0, 31) == 0) take_eager = ~take_eager;
      take_draw = take_eager ? 0 : $urandom_range(0, 8);
      out_ch.ready <= (take_draw == 0);
      take_wait    <= take_draw;
    end else if (take_wait > 0) begin
      out_ch.ready <= (take_wait == 1);
      take_wait    <= take_wait - 1;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("moving_average_with_replace_core test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    in_ch.valid  = 1'b0;
    in_ch.op     = mavg_pkg::OP_PUSH;
    in_ch.sample = '0;
    out_ch.ready = 1'b0;
    win_len      = mavg_pkg::LEN_RESET;
    clear_window();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed beats at the reset length of 20: replace into an empty window,
    // full-scale values both ways, odd negative sums, then the usual mix.
    queue_beat(mavg_pkg::OP_REPLACE, 32'sh7FFF_FFFF);
    queue_beat(mavg_pkg::OP_PUSH,    32'sh8000_0000);   // sum -1 over 2 truncates to 0
    queue_beat(mavg_pkg::OP_REPLACE, -32'sd1);
    queue_beat(mavg_pkg::OP_PUSH,    -32'sd3);
    queue_beat(mavg_pkg::OP_REPLACE, 32'sh8000_0000);
    queue_beat(mavg_pkg::OP_PUSH,    32'sd0);
    queue_beat(mavg_pkg::OP_PUSH,    32'sd1);
    queue_beat(mavg_pkg::OP_PUSH,    -32'sd7);
    queue_beat(mavg_pkg::OP_REPLACE, 32'sh7FFF_FFFF);
    queue_beat(mavg_pkg::OP_PUSH,    32'sh0001_8000);   // 1.5 in Q16.16
    queue_beat(mavg_pkg::OP_PUSH,    -32'sh0000_8000);  // -0.5
    queue_beat(mavg_pkg::OP_REPLACE, 32'sh5555_5555);
    queue_beat(mavg_pkg::OP_PUSH,    32'shAAAA_AAAA);
    queue_random_beats(60);

    // Length extremes: 0 acts as 1, 1025 clamps to the full ring and runs long
    // enough to wrap it, 2047 is the register maximum.
    run_phase(11'd0,    50);
    run_phase(11'd1,    50);
    run_phase(11'd2,    60);
    run_phase(11'd1024, 30);
    run_phase(11'd1025, 1100);
    run_phase(11'd2047, 30);
    for (int p = 0; p < 4; p++)
      run_phase(LEN_W'($urandom_range(3, 40)), 60);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_averages.size() == 0) begin
      $display("moving_average_with_replace_core test passed");
    end else begin
      $display("moving_average_with_replace_core test failed");
    end
    $finish;
  end

endmodule
